// ===== rtl/yp2r_pkg.sv =====
// ----------------------------------------------------------------------------
// yp2r_pkg
// Shared widths, register indexes and reset values for the YUV pair to RGB
// converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package yp2r_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 19;
  localparam int unsigned GAIN_W     = 18;
  localparam int unsigned COEF_W     = 19;

  // luma term after >>13, chroma green sum width
  localparam int unsigned LUMA_T_W   = 13;
  localparam int unsigned CHROMA_T_W = 15;

  localparam logic [CFG_IDX_W-1:0] REG_LUMA_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_U_TO_BLUE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_U_TO_GREEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_V_TO_GREEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_V_TO_RED   = 3'd4;

  localparam logic        [GAIN_W-1:0] LUMA_GAIN_RST  = 18'd76309;
  localparam logic signed [COEF_W-1:0] U_TO_BLUE_RST  = 19'sd132201;
  localparam logic signed [COEF_W-1:0] U_TO_GREEN_RST = -19'sd25674;
  localparam logic signed [COEF_W-1:0] V_TO_GREEN_RST = -19'sd53278;
  localparam logic signed [COEF_W-1:0] V_TO_RED_RST   = 19'sd104597;

  localparam logic [7:0] BLACK_LEVEL   = 8'd16;
  localparam logic [7:0] CHROMA_OFFSET = 8'd128;

endpackage

`default_nettype wire

// ===== rtl/yp2r_chan.sv =====
// ----------------------------------------------------------------------------
// yp2r_chan
// One color channel: luma term plus chroma term, floor shift by 3 and
// saturation to 0..255.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module yp2r_chan import yp2r_pkg::*; (
  input  wire logic        [LUMA_T_W-1:0]   luma_i,
  input  wire logic signed [CHROMA_T_W-1:0] chroma_i,
  output      logic        [7:0]            chan_o
);

  logic signed [16:0] sum;
  logic signed [13:0] shifted;

  always_comb begin
    sum     = $signed({4'b0000, luma_i}) + $signed({{2{chroma_i[CHROMA_T_W-1]}}, chroma_i});
    shifted = sum[16:3];
    if (shifted[13]) begin
      chan_o = 8'd0;
    end else if (|shifted[12:8]) begin
      chan_o = 8'd255;
    end else begin
      chan_o = shifted[7:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/yuv_pair_to_rgb_top.sv =====
// ----------------------------------------------------------------------------
// yuv_pair_to_rgb_top
// BT.601 limited-range YCbCr to RGB for one horizontal pixel pair.
// ----------------------------------------------------------------------------
// throughput: one pixel pair per clock while stall_i is low, four register stages
//   (offset, multiply, shift and sum, saturate) each with its own valid bit
// a stall only freezes stages that are full, bubbles still close up
// reset clears all valid bits and loads the default BT.601 coefficients
`timescale 1ns / 1ps
`default_nettype none

module yuv_pair_to_rgb_top import yp2r_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  valid_i,
  output      logic                  stall_o,
  input  wire logic [7:0]            luma_even_i,
  input  wire logic [7:0]            luma_odd_i,
  input  wire logic [7:0]            chroma_u_i,
  input  wire logic [7:0]            chroma_v_i,
  output      logic                  valid_o,
  input  wire logic                  stall_i,
  output      logic [7:0]            red_even_o,
  output      logic [7:0]            green_even_o,
  output      logic [7:0]            blue_even_o,
  output      logic [7:0]            red_odd_o,
  output      logic [7:0]            green_odd_o,
  output      logic [7:0]            blue_odd_o
);

  // configuration registers
  logic        [GAIN_W-1:0] luma_gain_q;
  logic signed [COEF_W-1:0] u_to_blue_q, u_to_green_q, v_to_green_q, v_to_red_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      luma_gain_q  <= LUMA_GAIN_RST;
      u_to_blue_q  <= U_TO_BLUE_RST;
      u_to_green_q <= U_TO_GREEN_RST;
      v_to_green_q <= V_TO_GREEN_RST;
      v_to_red_q   <= V_TO_RED_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LUMA_GAIN:  luma_gain_q  <= cfg_data_i[GAIN_W-1:0];
        REG_U_TO_BLUE:  u_to_blue_q  <= $signed(cfg_data_i);
        REG_U_TO_GREEN: u_to_green_q <= $signed(cfg_data_i);
        REG_V_TO_GREEN: v_to_green_q <= $signed(cfg_data_i);
        REG_V_TO_RED:   v_to_red_q   <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // stage valid bits and advance enables
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  logic s1_en, s2_en, s3_en, s4_en;

  assign s4_en   = !s4_vld_q || !stall_i;
  assign s3_en   = !s3_vld_q || s4_en;
  assign s2_en   = !s2_vld_q || s3_en;
  assign s1_en   = !s1_vld_q || s2_en;
  assign stall_o = !s1_en;
  assign valid_o = s4_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      if (s1_en) s1_vld_q <= valid_i;
      if (s2_en) s2_vld_q <= s1_vld_q;
      if (s3_en) s3_vld_q <= s2_vld_q;
      if (s4_en) s4_vld_q <= s3_vld_q;
    end
  end

  // stage 1: remove black level and chroma offset
  logic        [7:0] yoff_e_d, yoff_e_q, yoff_o_d, yoff_o_q;
  logic signed [8:0] uc_d, uc_q, vc_d, vc_q;

  always_comb begin
    yoff_e_d = (luma_even_i < BLACK_LEVEL) ? 8'd0 : luma_even_i - BLACK_LEVEL;
    yoff_o_d = (luma_odd_i < BLACK_LEVEL) ? 8'd0 : luma_odd_i - BLACK_LEVEL;
    uc_d     = $signed({1'b0, chroma_u_i}) - $signed({1'b0, CHROMA_OFFSET});
    vc_d     = $signed({1'b0, chroma_v_i}) - $signed({1'b0, CHROMA_OFFSET});
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && valid_i) begin
      yoff_e_q <= yoff_e_d;
      yoff_o_q <= yoff_o_d;
      uc_q     <= uc_d;
      vc_q     <= vc_d;
    end
  end

  // stage 2: products
  logic        [25:0] pe_d, pe_q, po_d, po_q;
  logic signed [26:0] pb_d, pb_q, pgu_d, pgu_q, pgv_d, pgv_q, pr_d, pr_q;

  always_comb begin
    pe_d  = luma_gain_q * yoff_e_q;
    po_d  = luma_gain_q * yoff_o_q;
    pb_d  = u_to_blue_q * uc_q;
    pgu_d = u_to_green_q * uc_q;
    pgv_d = v_to_green_q * vc_q;
    pr_d  = v_to_red_q * vc_q;
  end

  always_ff @(posedge clk_i) begin
    if (s2_en && s1_vld_q) begin
      pe_q  <= pe_d;
      po_q  <= po_d;
      pb_q  <= pb_d;
      pgu_q <= pgu_d;
      pgv_q <= pgv_d;
      pr_q  <= pr_d;
    end
  end

  // stage 3: floor shift by 13, green terms summed
  // chroma terms stay inside 14 signed bits, so the 15-bit wrap never acts
  logic        [LUMA_T_W-1:0]   le_q, lo_q;
  logic signed [CHROMA_T_W-1:0] cb_d, cb_q, cg_d, cg_q, cr_d, cr_q;

  always_comb begin
    cb_d = $signed({pb_q[26], pb_q[26:13]});
    cr_d = $signed({pr_q[26], pr_q[26:13]});
    cg_d = $signed({pgu_q[26], pgu_q[26:13]}) + $signed({pgv_q[26], pgv_q[26:13]});
  end

  always_ff @(posedge clk_i) begin
    if (s3_en && s2_vld_q) begin
      le_q <= pe_q[25:13];
      lo_q <= po_q[25:13];
      cb_q <= cb_d;
      cg_q <= cg_d;
      cr_q <= cr_d;
    end
  end

  // stage 4: channel sums and saturation into the output register
  logic [7:0] re_d, ge_d, be_d, ro_d, go_d, bo_d;

  yp2r_chan u_chan_re (.luma_i(le_q), .chroma_i(cr_q), .chan_o(re_d));
  yp2r_chan u_chan_ge (.luma_i(le_q), .chroma_i(cg_q), .chan_o(ge_d));
  yp2r_chan u_chan_be (.luma_i(le_q), .chroma_i(cb_q), .chan_o(be_d));
  yp2r_chan u_chan_ro (.luma_i(lo_q), .chroma_i(cr_q), .chan_o(ro_d));
  yp2r_chan u_chan_go (.luma_i(lo_q), .chroma_i(cg_q), .chan_o(go_d));
  yp2r_chan u_chan_bo (.luma_i(lo_q), .chroma_i(cb_q), .chan_o(bo_d));

  always_ff @(posedge clk_i) begin
    if (s4_en && s3_vld_q) begin
      red_even_o   <= re_d;
      green_even_o <= ge_d;
      blue_even_o  <= be_d;
      red_odd_o    <= ro_d;
      green_odd_o  <= go_d;
      blue_odd_o   <= bo_d;
    end
  end

  // input back-pressure only when every stage holds a word
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (s1_vld_q && s2_vld_q && s3_vld_q && s4_vld_q))
    else $error("stall raised with a free stage");

  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o) |=> s1_vld_q)
    else $error("accepted word missing from first stage");

  a_hold_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_vld_q && !s3_en) |=> (s2_vld_q && $stable(pb_q) && $stable(pe_q)))
    else $error("blocked stage lost its word");

  a_black_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o && (luma_even_i < BLACK_LEVEL)) |=> (yoff_e_q == 8'd0))
    else $error("luma below black level not clamped");

endmodule

`default_nettype wire
